>>> design/lcs_pkg.sv
// Shared types, widths and helpers for the line clip splitter.
package lcs_pkg;

  localparam int CW = 12;          // coordinate width
  localparam int DW = CW + 2;      // fraction numerator / denominator width
  localparam int MW = CW + DW;     // one product of the interpolation
  localparam int NW = MW + 1;      // interpolation numerator
  localparam int QB = CW;          // quotient bits, one per divider stage
  localparam int SW = 2 * (CW + 1);// squared distance term
  localparam int IW = 3;           // config index width

  localparam logic [IW-1:0] REG_A_X = 3'd0;
  localparam logic [IW-1:0] REG_A_Y = 3'd1;
  localparam logic [IW-1:0] REG_B_X = 3'd2;
  localparam logic [IW-1:0] REG_B_Y = 3'd3;

  typedef enum logic [2:0] {
    K_BOTH_IN,
    K_REJECT,
    K_START_IN,
    K_END_IN,
    K_CROSS
  } kind_t;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
  } coord_t;

  typedef struct packed {
    logic signed [CW-1:0] lb;
    logic signed [CW-1:0] rb;
    logic signed [CW-1:0] ub;
    logic signed [CW-1:0] db;
  } win_t;

  // One axis: entering fraction en/dd, leaving fraction ln/dd, rejection flag.
  typedef struct packed {
    logic signed [DW-1:0] en;
    logic signed [DW-1:0] ln;
    logic signed [DW-1:0] dd;
    logic                 rej;
  } axis_t;

  function automatic logic frac_gt(input logic signed [DW-1:0] an, ad, bn, bd);
    logic signed [2*DW-1:0] l;
    logic signed [2*DW-1:0] r;
    l = (2*DW)'(an) * (2*DW)'(bd);
    r = (2*DW)'(bn) * (2*DW)'(ad);
    return l > r;
  endfunction

  function automatic axis_t axis_prep(input logic signed [CW-1:0] p, lo, hi,
                                      input logic signed [CW:0] d);
    axis_t a;
    logic signed [DW-1:0] pe;
    logic signed [DW-1:0] loe;
    logic signed [DW-1:0] hie;
    logic signed [DW-1:0] de;
    pe  = DW'(p);
    loe = DW'(lo);
    hie = DW'(hi);
    de  = DW'(d);
    a.rej = 1'b0;
    if (d > 0) begin
      a.dd = de;
      a.en = loe - pe;
      a.ln = hie - pe;
    end else if (d < 0) begin
      a.dd = -de;
      a.en = pe - hie;
      a.ln = pe - loe;
    end else begin
      a.dd  = DW'(1);
      a.en  = '0;
      a.ln  = DW'(1);
      a.rej = (p < lo) || (p > hi);
    end
    // clamp entering at 0 and leaving at 1
    if (a.en < 0) a.en = '0;
    if (a.ln > a.dd) a.ln = a.dd;
    return a;
  endfunction

endpackage

>>> design/line_clip_split_segments.sv
// Top level of the Liang-Barsky segment clipper that splits a segment into pieces.
// Pipeline: an accepted item passes 3 setup stages, 13 divider stages, the distance
//   stage and the output register before the first piece of its segment appears.
// Throughput: one segment per cycle while out_tready is high and each segment is one
//   piece; the output register emits pieces in turn, holding the pipeline to the last.
// Reset: synchronous active-low rst_n clears all valid bits and the corners to 0.
module line_clip_split_segments (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lcs_pkg::IW-1:0]    cfg_index,
  input  logic [lcs_pkg::CW-1:0]    cfg_data,
  // input segments
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [4*lcs_pkg::CW-1:0]  in_tdata,   // start_x, start_y, end_x, end_y
  // output pieces
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [4*lcs_pkg::CW-1:0]  out_tdata,  // piece_x0, piece_y0, piece_x1, piece_y1
  output logic                      out_tuser,  // piece_inside
  output logic                      out_tlast   // piece_last
);

  // Corner registers; writes to unknown indexes drop silently.
  logic signed [lcs_pkg::CW-1:0] ax_r, ay_r, bx_r, by_r;
  lcs_pkg::win_t                 win;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      ay_r <= '0;
      bx_r <= '0;
      by_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lcs_pkg::REG_A_X: ax_r <= cfg_data;
        lcs_pkg::REG_A_Y: ay_r <= cfg_data;
        lcs_pkg::REG_B_X: bx_r <= cfg_data;
        lcs_pkg::REG_B_Y: by_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Normalize the window straight from the corners, so an item accepted in
  // the cycle right after a corner write already sees the new window.
  always_comb begin
    win.lb = (ax_r < bx_r) ? ax_r : bx_r;
    win.rb = (ax_r < bx_r) ? bx_r : ax_r;
    win.ub = (ay_r < by_r) ? ay_r : by_r;
    win.db = (ay_r < by_r) ? by_r : ay_r;
  end

  // The whole pipeline advances together whenever the output register can
  // take a new segment; a stall freezes every stage.
  logic            en;
  lcs_pkg::coord_t in_c;

  assign in_tready = en;
  assign in_c.x1   = in_tdata[lcs_pkg::CW-1:0];
  assign in_c.y1   = in_tdata[2*lcs_pkg::CW-1:lcs_pkg::CW];
  assign in_c.x2   = in_tdata[3*lcs_pkg::CW-1:2*lcs_pkg::CW];
  assign in_c.y2   = in_tdata[4*lcs_pkg::CW-1:3*lcs_pkg::CW];

  logic                          v3;
  lcs_pkg::coord_t               c3;
  lcs_pkg::kind_t                k3;
  logic signed [lcs_pkg::NW-1:0] nb1x, nb1y, nb2x, nb2y;
  logic signed [lcs_pkg::DW-1:0] dl, de;

  lcs_setup u_setup (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (in_tvalid),
    .in_c   (in_c),
    .win    (win),
    .v3_r   (v3),
    .c3_r   (c3),
    .k3_r   (k3),
    .nb1x_r (nb1x),
    .nb1y_r (nb1y),
    .nb2x_r (nb2x),
    .nb2y_r (nb2y),
    .dl_r   (dl),
    .de_r   (de)
  );

  // Four dividers: leaving point (b1) over the leaving denominator, entering
  // point (b2) over the entering one. Rejected and all-inside segments run
  // through as well; their quotients are simply not used.
  logic signed [lcs_pkg::CW-1:0] b1x, b1y, b2x, b2y;

  lcs_div u_div_b1x (.clk(clk), .en(en), .num(nb1x), .den(dl), .quo(b1x));
  lcs_div u_div_b1y (.clk(clk), .en(en), .num(nb1y), .den(dl), .quo(b1y));
  lcs_div u_div_b2x (.clk(clk), .en(en), .num(nb2x), .den(de), .quo(b2x));
  lcs_div u_div_b2y (.clk(clk), .en(en), .num(nb2y), .den(de), .quo(b2y));

  // Carry endpoints, kind and valid alongside the divider stages.
  logic            dv_r [0:lcs_pkg::QB];
  lcs_pkg::coord_t dc_r [0:lcs_pkg::QB];
  lcs_pkg::kind_t  dk_r [0:lcs_pkg::QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= lcs_pkg::QB; i++) dv_r[i] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= v3;
      for (int i = 1; i <= lcs_pkg::QB; i++) dv_r[i] <= dv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dc_r[0] <= c3;
      dk_r[0] <= k3;
      for (int i = 1; i <= lcs_pkg::QB; i++) begin
        dc_r[i] <= dc_r[i-1];
        dk_r[i] <= dk_r[i-1];
      end
    end
  end

  lcs_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_v       (dv_r[lcs_pkg::QB]),
    .in_c       (dc_r[lcs_pkg::QB]),
    .in_k       (dk_r[lcs_pkg::QB]),
    .b1x        (b1x),
    .b1y        (b1y),
    .b2x        (b2x),
    .b2y        (b2y),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // An empty output register never blocks the input.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  // A piece that is not the last is always followed by another piece.
  a_more_pieces: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("segment pieces cut short");

  // While a non-final piece waits, the pipeline holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("pipeline advanced mid-segment");

endmodule

>>> design/lcs_setup.sv
// Clip parameter stages: axis setup, fraction select, reject test and numerators.
module lcs_setup (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  lcs_pkg::coord_t               in_c,
  input  lcs_pkg::win_t                 win,
  output logic                          v3_r,
  output lcs_pkg::coord_t               c3_r,
  output lcs_pkg::kind_t                k3_r,
  output logic signed [lcs_pkg::NW-1:0] nb1x_r,
  output logic signed [lcs_pkg::NW-1:0] nb1y_r,
  output logic signed [lcs_pkg::NW-1:0] nb2x_r,
  output logic signed [lcs_pkg::NW-1:0] nb2y_r,
  output logic signed [lcs_pkg::DW-1:0] dl_r,
  output logic signed [lcs_pkg::DW-1:0] de_r
);

  // stage 1
  logic signed [lcs_pkg::CW:0] dx, dy;
  logic                        in1, in2;
  logic                        v1_r, in1_r, in2_r;
  lcs_pkg::coord_t             c1_r;
  lcs_pkg::axis_t              ax_r, ay_r;
  logic signed [lcs_pkg::CW:0] dx1_r, dy1_r;

  assign dx  = (lcs_pkg::CW+1)'(in_c.x2) - (lcs_pkg::CW+1)'(in_c.x1);
  assign dy  = (lcs_pkg::CW+1)'(in_c.y2) - (lcs_pkg::CW+1)'(in_c.y1);
  assign in1 = in_c.x1 >= win.lb && in_c.x1 <= win.rb && in_c.y1 >= win.ub && in_c.y1 <= win.db;
  assign in2 = in_c.x2 >= win.lb && in_c.x2 <= win.rb && in_c.y2 >= win.ub && in_c.y2 <= win.db;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= in_c;
      in1_r <= in1;
      in2_r <= in2;
      dx1_r <= dx;
      dy1_r <= dy;
      ax_r  <= lcs_pkg::axis_prep(in_c.x1, win.lb, win.rb, dx);
      ay_r  <= lcs_pkg::axis_prep(in_c.y1, win.ub, win.db, dy);
    end
  end

  // stage 2: largest entering and smallest leaving fraction
  logic                          v2_r, in1_2_r, in2_2_r, rej2_r;
  lcs_pkg::coord_t               c2_r;
  logic signed [lcs_pkg::CW:0]   dx2_r, dy2_r;
  logic signed [lcs_pkg::DW-1:0] en2_r, ed2_r, ln2_r, ld2_r;
  logic                          gx, gl;

  assign gx = lcs_pkg::frac_gt(ax_r.en, ax_r.dd, ay_r.en, ay_r.dd);
  assign gl = lcs_pkg::frac_gt(ax_r.ln, ax_r.dd, ay_r.ln, ay_r.dd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r    <= c1_r;
      in1_2_r <= in1_r;
      in2_2_r <= in2_r;
      dx2_r   <= dx1_r;
      dy2_r   <= dy1_r;
      rej2_r  <= ax_r.rej || ay_r.rej;
      en2_r   <= gx ? ax_r.en : ay_r.en;
      ed2_r   <= gx ? ax_r.dd : ay_r.dd;
      ln2_r   <= gl ? ay_r.ln : ax_r.ln;
      ld2_r   <= gl ? ay_r.dd : ax_r.dd;
    end
  end

  // stage 3: reject test, piece kind and interpolation numerators
  logic           rej3;
  lcs_pkg::kind_t kind;
  logic signed [lcs_pkg::MW-1:0] p_x1l, p_lx, p_y1l, p_ly, p_x1e, p_ex, p_y1e, p_ey;

  assign rej3  = rej2_r || lcs_pkg::frac_gt(en2_r, ed2_r, ln2_r, ld2_r);
  assign p_x1l = lcs_pkg::MW'(c2_r.x1) * lcs_pkg::MW'(ld2_r);
  assign p_lx  = lcs_pkg::MW'(ln2_r) * lcs_pkg::MW'(dx2_r);
  assign p_y1l = lcs_pkg::MW'(c2_r.y1) * lcs_pkg::MW'(ld2_r);
  assign p_ly  = lcs_pkg::MW'(ln2_r) * lcs_pkg::MW'(dy2_r);
  assign p_x1e = lcs_pkg::MW'(c2_r.x1) * lcs_pkg::MW'(ed2_r);
  assign p_ex  = lcs_pkg::MW'(en2_r) * lcs_pkg::MW'(dx2_r);
  assign p_y1e = lcs_pkg::MW'(c2_r.y1) * lcs_pkg::MW'(ed2_r);
  assign p_ey  = lcs_pkg::MW'(en2_r) * lcs_pkg::MW'(dy2_r);

  always_comb begin
    if (in1_2_r && in2_2_r) kind = lcs_pkg::K_BOTH_IN;
    else if (rej3)          kind = lcs_pkg::K_REJECT;
    else if (in1_2_r)       kind = lcs_pkg::K_START_IN;
    else if (in2_2_r)       kind = lcs_pkg::K_END_IN;
    else                    kind = lcs_pkg::K_CROSS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_r   <= c2_r;
      k3_r   <= kind;
      nb1x_r <= lcs_pkg::NW'(p_x1l) + lcs_pkg::NW'(p_lx);
      nb1y_r <= lcs_pkg::NW'(p_y1l) + lcs_pkg::NW'(p_ly);
      nb2x_r <= lcs_pkg::NW'(p_x1e) + lcs_pkg::NW'(p_ex);
      nb2y_r <= lcs_pkg::NW'(p_y1e) + lcs_pkg::NW'(p_ey);
      dl_r   <= ld2_r;
      de_r   <= ed2_r;
    end
  end

endmodule

>>> design/lcs_div.sv
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero.
module lcs_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [lcs_pkg::NW-1:0] num,
  input  logic signed [lcs_pkg::DW-1:0] den,
  output logic signed [lcs_pkg::CW-1:0] quo
);

  logic [lcs_pkg::NW-2:0] rem_r [0:lcs_pkg::QB-1];
  logic [lcs_pkg::DW-2:0] d_r   [0:lcs_pkg::QB-1];
  logic [lcs_pkg::QB-1:0] q_r   [0:lcs_pkg::QB];
  logic                   neg_r [0:lcs_pkg::QB];

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= num < 0;
      rem_r[0] <= (num < 0) ? (lcs_pkg::NW-1)'(-num) : (lcs_pkg::NW-1)'(num);
      d_r[0]   <= den[lcs_pkg::DW-2:0];
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < lcs_pkg::QB; k++) begin : g_stage
    logic [lcs_pkg::NW-2:0] sh;
    logic                   ge;
    assign sh = (lcs_pkg::NW-1)'(d_r[k]) << (lcs_pkg::QB - 1 - k);
    assign ge = rem_r[k] >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k+1]   <= {q_r[k][lcs_pkg::QB-2:0], ge};
        neg_r[k+1] <= neg_r[k];
      end
    end

    if (k < lcs_pkg::QB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= ge ? rem_r[k] - sh : rem_r[k];
          d_r[k+1]   <= d_r[k];
        end
      end
    end
  end

  assign quo = neg_r[lcs_pkg::QB] ? -q_r[lcs_pkg::QB] : q_r[lcs_pkg::QB];

endmodule

>>> design/lcs_emit.sv
// Crossing point ordering and piece output register.
module lcs_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_v,
  input  lcs_pkg::coord_t               in_c,
  input  lcs_pkg::kind_t                in_k,
  input  logic signed [lcs_pkg::CW-1:0] b1x,
  input  logic signed [lcs_pkg::CW-1:0] b1y,
  input  logic signed [lcs_pkg::CW-1:0] b2x,
  input  logic signed [lcs_pkg::CW-1:0] b2y,
  output logic                          en,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [4*lcs_pkg::CW-1:0]      out_tdata,
  output logic                          out_tuser,
  output logic                          out_tlast
);

  // distance stage
  logic signed [lcs_pkg::CW-1:0] rx, ry;
  logic signed [lcs_pkg::CW:0]   e1x, e1y, e2x, e2y;
  logic                          vd_r;
  lcs_pkg::coord_t               cd_r;
  lcs_pkg::kind_t                kd_r;
  logic signed [lcs_pkg::CW-1:0] b1x_r, b1y_r, b2x_r, b2y_r;
  logic [lcs_pkg::SW:0]          d1_r, d2_r;

  assign rx  = (in_k == lcs_pkg::K_START_IN) ? in_c.x2 : in_c.x1;
  assign ry  = (in_k == lcs_pkg::K_START_IN) ? in_c.y2 : in_c.y1;
  assign e1x = (lcs_pkg::CW+1)'(b1x) - (lcs_pkg::CW+1)'(rx);
  assign e1y = (lcs_pkg::CW+1)'(b1y) - (lcs_pkg::CW+1)'(ry);
  assign e2x = (lcs_pkg::CW+1)'(b2x) - (lcs_pkg::CW+1)'(rx);
  assign e2y = (lcs_pkg::CW+1)'(b2y) - (lcs_pkg::CW+1)'(ry);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd_r  <= in_c;
      kd_r  <= in_k;
      b1x_r <= b1x;
      b1y_r <= b1y;
      b2x_r <= b2x;
      b2y_r <= b2y;
      d1_r  <= (lcs_pkg::SW+1)'(lcs_pkg::SW'(e1x * e1x)) +
               (lcs_pkg::SW+1)'(lcs_pkg::SW'(e1y * e1y));
      d2_r  <= (lcs_pkg::SW+1)'(lcs_pkg::SW'(e2x * e2x)) +
               (lcs_pkg::SW+1)'(lcs_pkg::SW'(e2y * e2y));
    end
  end

  // output register: holds one segment and walks its pieces
  logic                          hv_r;
  logic [1:0]                    idx_r;
  lcs_pkg::coord_t               ch_r;
  lcs_pkg::kind_t                kh_r;
  logic signed [lcs_pkg::CW-1:0] p1x_r, p1y_r, p2x_r, p2y_r;
  logic                          swap;
  logic signed [lcs_pkg::CW-1:0] ox0, oy0, ox1, oy1;
  logic                          pc_inside, last;

  assign swap = d1_r > d2_r;
  assign en   = !hv_r || (out_tready && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r  <= 1'b0;
      idx_r <= '0;
    end else if (en) begin
      hv_r  <= vd_r;
      idx_r <= '0;
    end else if (out_tready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch_r  <= cd_r;
      kh_r  <= kd_r;
      p1x_r <= swap ? b2x_r : b1x_r;
      p1y_r <= swap ? b2y_r : b1y_r;
      p2x_r <= swap ? b1x_r : b2x_r;
      p2y_r <= swap ? b1y_r : b2y_r;
    end
  end

  always_comb begin
    ox0       = ch_r.x1;
    oy0       = ch_r.y1;
    ox1       = ch_r.x2;
    oy1       = ch_r.y2;
    pc_inside = 1'b0;
    last      = 1'b1;
    case (kh_r)
      lcs_pkg::K_BOTH_IN: begin
        pc_inside = 1'b1;
      end
      lcs_pkg::K_START_IN, lcs_pkg::K_END_IN: begin
        if (idx_r == 2'd0) begin
          ox1       = p1x_r;
          oy1       = p1y_r;
          pc_inside = (kh_r == lcs_pkg::K_START_IN);
          last      = 1'b0;
        end else begin
          ox0       = p1x_r;
          oy0       = p1y_r;
          pc_inside = (kh_r == lcs_pkg::K_END_IN);
        end
      end
      lcs_pkg::K_CROSS: begin
        if (idx_r == 2'd0) begin
          ox1  = p1x_r;
          oy1  = p1y_r;
          last = 1'b0;
        end else if (idx_r == 2'd1) begin
          ox0       = p1x_r;
          oy0       = p1y_r;
          ox1       = p2x_r;
          oy1       = p2y_r;
          pc_inside = 1'b1;
          last      = 1'b0;
        end else begin
          ox0 = p2x_r;
          oy0 = p2y_r;
        end
      end
      default: begin
        pc_inside = 1'b0;
      end
    endcase
  end

  assign out_tvalid = hv_r;
  assign out_tdata  = {oy1, ox1, oy0, ox0};
  assign out_tuser  = pc_inside;
  assign out_tlast  = last;

endmodule
